### hdl/assert_macros.svh
// Assertion macros used by the RTL of the free extent allocator (fea_ctrl).
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/fea_pkg.sv
// Package of the free extent allocator: slot type, state codes, status
// and function codes, stream data widths. No dependencies.
package fea_pkg;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } slot_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_FREE,
        ST_PICK,
        ST_FIND,
        ST_APPLY,
        ST_DONE
    } state_t;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NO_SPACE = 2'd1;
    localparam logic [1:0] STS_NO_SLOT  = 2'd2;
    localparam logic [1:0] STS_NULL     = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'd1;

    localparam logic [31:0] POOL_BASE_RST = 32'd0;
    localparam logic [31:0] POOL_SIZE_RST = 32'd65536;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 104;

endpackage

### hdl/fea_cell.sv
// One slot of the rotating extent table: holds a (start, length) pair.
// Depends on fea_pkg.
module fea_cell #(
    parameter bit HEAD = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fea_pkg::cell_ctl_t ctl,
    input  fea_pkg::slot_t    load_val,
    input  fea_pkg::slot_t    next_in,
    output fea_pkg::slot_t    slot
);

    fea_pkg::slot_t slot_reg;
    fea_pkg::slot_t slot_next;

    // refill has priority, otherwise take the neighbor's slot on a shift
    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.load)
        begin
            slot_next = load_val;
        end
        else if (ctl.shift)
        begin
            slot_next = next_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg.start <= HEAD ? fea_pkg::POOL_BASE_RST : 32'd0;
            slot_reg.len   <= HEAD ? fea_pkg::POOL_SIZE_RST : 32'd0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

### hdl/fea_ctrl.sv
// Sequencer of the free extent allocator: request handshake, scan passes
// over the head cell, merge search and result register.
// Depends on fea_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fea_ctrl #(
    parameter int SLOT_COUNT   = 16,
    parameter int HEADER_BYTES = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fea_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fea_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                             cfg_we,
    input  logic [fea_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data,
    input  fea_pkg::slot_t                   head,
    output fea_pkg::slot_t                   wb,
    output fea_pkg::slot_t                   load_val,
    output fea_pkg::cell_ctl_t               cell_ctl
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    fea_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] cand_reg, cand_next;
    logic [IDX_W-1:0] jidx_reg, jidx_next;
    logic             done_reg, done_next;
    logic             found_reg, found_next;
    logic             ok_reg, ok_next;
    logic             retry_alloc_reg, retry_alloc_next;
    logic [31:0]      tail_reg, tail_next;
    logic [31:0]      jlen_reg, jlen_next;
    logic [31:0]      total_reg, total_next;
    logic [31:0]      granted_reg, granted_next;
    logic [1:0]       status_reg, status_next;
    logic [1:0]       func_reg, func_next;
    logic [31:0]      req_reg, req_next;
    logic [31:0]      addr_reg, addr_next;
    logic [31:0]      base_reg, base_next;
    logic [31:0]      size_reg, size_next;
    logic             m_valid_reg, m_valid_next;
    logic [fea_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic        accept;
    logic        shifting;
    logic        circ_end;
    logic        cand_last;
    logic        out_load;
    logic [32:0] need;
    logic [31:0] flen;
    logic [31:0] alloc_len;
    logic        alloc_hit;
    logic        free_hit;
    logic        find_hit;

    assign accept    = s_tvalid && s_tready;
    assign shifting  = (state_reg == fea_pkg::ST_ALLOC) || (state_reg == fea_pkg::ST_FREE)
                    || (state_reg == fea_pkg::ST_PICK) || (state_reg == fea_pkg::ST_FIND)
                    || (state_reg == fea_pkg::ST_APPLY);
    assign circ_end  = shifting && (cnt_reg == LAST_IDX);
    assign cand_last = (cand_reg == LAST_IDX);
    assign out_load  = (state_reg == fea_pkg::ST_DONE) && (!m_valid_reg || m_tready);

    // block size with header, full precision for alloc, saturated for free
    assign need      = {1'b0, req_reg} + 33'(HEADER_BYTES);
    assign flen      = need[32] ? 32'hFFFF_FFFF : need[31:0];
    assign alloc_len = head.len - need[31:0];
    assign alloc_hit = !done_reg && (head.len != 32'd0) && ({1'b0, head.len} >= need);
    assign free_hit  = !done_reg && (head.len == 32'd0);
    assign find_hit  = !found_reg && (cnt_reg != cand_reg) && (head.len != 32'd0)
                    && (head.start == tail_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fea_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tdata[1:0] == fea_pkg::FUNC_ALLOC)
                    begin
                        state_next = fea_pkg::ST_ALLOC;
                    end
                    else if (s_tdata[1:0] == fea_pkg::FUNC_FREE && s_tdata[65:34] != 32'd0)
                    begin
                        state_next = fea_pkg::ST_FREE;
                    end
                    else
                    begin
                        state_next = fea_pkg::ST_DONE;
                    end
                end
            end
            fea_pkg::ST_ALLOC:
            begin
                if (circ_end)
                begin
                    state_next = (done_reg || alloc_hit) ? fea_pkg::ST_DONE : fea_pkg::ST_PICK;
                end
            end
            fea_pkg::ST_FREE:
            begin
                if (circ_end)
                begin
                    state_next = (done_reg || free_hit) ? fea_pkg::ST_DONE : fea_pkg::ST_PICK;
                end
            end
            fea_pkg::ST_PICK:
            begin
                if (circ_end)
                begin
                    if (ok_next)
                    begin
                        state_next = fea_pkg::ST_FIND;
                    end
                    else if (cand_last)
                    begin
                        state_next = fea_pkg::ST_DONE;
                    end
                end
            end
            fea_pkg::ST_FIND:
            begin
                if (circ_end)
                begin
                    if (found_reg || find_hit)
                    begin
                        state_next = fea_pkg::ST_APPLY;
                    end
                    else
                    begin
                        state_next = cand_last ? fea_pkg::ST_DONE : fea_pkg::ST_PICK;
                    end
                end
            end
            fea_pkg::ST_APPLY:
            begin
                if (circ_end)
                begin
                    state_next = retry_alloc_reg ? fea_pkg::ST_ALLOC : fea_pkg::ST_FREE;
                end
            end
            fea_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = fea_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fea_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs to the cell ring
    always_comb
    begin
        s_tready       = (state_reg == fea_pkg::ST_IDLE);
        cell_ctl.shift = shifting;
        cell_ctl.load  = cfg_we;
        load_val.start = (cfg_index == fea_pkg::CFG_POOL_BASE) ? cfg_data : base_reg;
        load_val.len   = (cfg_index == fea_pkg::CFG_POOL_SIZE) ? cfg_data : size_reg;
        wb             = head;
        case (state_reg)
            fea_pkg::ST_ALLOC:
            begin
                if (alloc_hit)
                begin
                    wb.len   = alloc_len;
                    wb.start = (alloc_len == 32'd0) ? 32'd0 : head.start + need[31:0];
                end
            end
            fea_pkg::ST_FREE:
            begin
                if (free_hit)
                begin
                    wb.len   = flen;
                    wb.start = (flen != 32'd0) ? addr_reg - 32'(HEADER_BYTES) : 32'd0;
                end
            end
            fea_pkg::ST_APPLY:
            begin
                if (cnt_reg == cand_reg)
                begin
                    wb.len = head.len + jlen_reg;
                end
                else if (cnt_reg == jidx_reg)
                begin
                    wb.start = 32'd0;
                    wb.len   = 32'd0;
                end
            end
            default:
            begin
                wb = head;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        cnt_next         = cnt_reg;
        cand_next        = cand_reg;
        jidx_next        = jidx_reg;
        done_next        = done_reg;
        found_next       = found_reg;
        ok_next          = ok_reg;
        retry_alloc_next = retry_alloc_reg;
        tail_next        = tail_reg;
        jlen_next        = jlen_reg;
        total_next       = total_reg;
        granted_next     = granted_reg;
        status_next      = status_reg;
        func_next        = func_reg;
        req_next         = req_reg;
        addr_next        = addr_reg;
        base_next        = base_reg;
        size_next        = size_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        if (shifting)
        begin
            cnt_next = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
        end

        // table refill on a configuration write
        if (cfg_we)
        begin
            if (cfg_index == fea_pkg::CFG_POOL_BASE)
            begin
                base_next = cfg_data;
            end
            if (cfg_index == fea_pkg::CFG_POOL_SIZE)
            begin
                size_next = cfg_data;
            end
            total_next = load_val.len;
        end

        // request intake
        if (accept)
        begin
            func_next        = s_tdata[1:0];
            req_next         = s_tdata[33:2];
            addr_next        = s_tdata[65:34];
            done_next        = 1'b0;
            granted_next     = 32'd0;
            retry_alloc_next = (s_tdata[1:0] == fea_pkg::FUNC_ALLOC);
            status_next      = (s_tdata[1:0] == fea_pkg::FUNC_FREE && s_tdata[65:34] == 32'd0)
                             ? fea_pkg::STS_NULL : fea_pkg::STS_OK;
        end

        case (state_reg)
            fea_pkg::ST_ALLOC:
            begin
                if (alloc_hit)
                begin
                    done_next    = 1'b1;
                    granted_next = head.start + 32'(HEADER_BYTES);
                    total_next   = total_reg - need[31:0];
                end
                if (circ_end)
                begin
                    cand_next = '0;
                end
            end
            fea_pkg::ST_FREE:
            begin
                if (free_hit)
                begin
                    done_next  = 1'b1;
                    total_next = total_reg + flen;
                end
                if (circ_end)
                begin
                    cand_next = '0;
                end
            end
            fea_pkg::ST_PICK:
            begin
                if (cnt_reg == cand_reg)
                begin
                    tail_next = head.start + head.len;
                    ok_next   = (head.len != 32'd0);
                end
                found_next = 1'b0;
                if (circ_end && !ok_next)
                begin
                    if (cand_last)
                    begin
                        status_next = retry_alloc_reg ? fea_pkg::STS_NO_SPACE
                                                      : fea_pkg::STS_NO_SLOT;
                    end
                    else
                    begin
                        cand_next = cand_reg + 1'b1;
                    end
                end
            end
            fea_pkg::ST_FIND:
            begin
                if (find_hit)
                begin
                    found_next = 1'b1;
                    jidx_next  = cnt_reg;
                    jlen_next  = head.len;
                end
                if (circ_end && !found_reg && !find_hit)
                begin
                    if (cand_last)
                    begin
                        status_next = retry_alloc_reg ? fea_pkg::STS_NO_SPACE
                                                      : fea_pkg::STS_NO_SLOT;
                    end
                    else
                    begin
                        cand_next = cand_reg + 1'b1;
                    end
                end
            end
            fea_pkg::ST_APPLY:
            begin
                done_next = 1'b0;
            end
            default:
            begin
                done_next = done_next;
            end
        endcase

        // result register
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {6'd0, size_reg - total_reg, total_reg, granted_reg, status_reg};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fea_pkg::ST_IDLE;
            cnt_reg         <= '0;
            cand_reg        <= '0;
            jidx_reg        <= '0;
            done_reg        <= 1'b0;
            found_reg       <= 1'b0;
            ok_reg          <= 1'b0;
            retry_alloc_reg <= 1'b0;
            total_reg       <= fea_pkg::POOL_SIZE_RST;
            status_reg      <= fea_pkg::STS_OK;
            base_reg        <= fea_pkg::POOL_BASE_RST;
            size_reg        <= fea_pkg::POOL_SIZE_RST;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            cand_reg        <= cand_next;
            jidx_reg        <= jidx_next;
            done_reg        <= done_next;
            found_reg       <= found_next;
            ok_reg          <= ok_next;
            retry_alloc_reg <= retry_alloc_next;
            total_reg       <= total_next;
            status_reg      <= status_next;
            base_reg        <= base_next;
            size_reg        <= size_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tail_reg    <= tail_next;
        jlen_reg    <= jlen_next;
        granted_reg <= granted_next;
        func_reg    <= func_next;
        req_reg     <= req_next;
        addr_reg    <= addr_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // the ring is back in table order while the sequencer is idle
    `ASSERT_ALWAYS(a_idle_aligned, (state_reg != fea_pkg::ST_IDLE) || (cnt_reg == '0),
        "ring not aligned while idle")
    // a merge is applied only after a partner was found
    `ASSERT_ALWAYS(a_apply_found, (state_reg != fea_pkg::ST_APPLY) || found_reg,
        "merge applied without a partner")
    // a finished result waits while the output register is stalled
    `ASSERT_NEXT(a_done_hold,
        (state_reg == fea_pkg::ST_DONE) && m_valid_reg && !m_tready,
        state_reg == fea_pkg::ST_DONE, "result lost under stall")
    // an allocation grant is reported only with status ok
    `ASSERT_ALWAYS(a_grant_ok,
        !(out_load && granted_reg != 32'd0 && status_reg != fea_pkg::STS_OK
          && func_reg == fea_pkg::FUNC_ALLOC),
        "grant with failing status")

endmodule

### hdl/free_extent_allocator.sv
// Free extent allocator, first fit over a table of free extents with
// pairwise merging when a request fails.
// Requests come in on s_tvalid/s_tready/s_tdata, one result per request
// leaves on m_tvalid/m_tready/m_tdata. A request is taken only when the
// sequencer is idle, so one request is in work at a time; a finished
// result sits in an output register and the next request may be taken
// while it waits for the receiver.
// The table is a ring of SLOT_COUNT cells that rotates one slot per cycle
// past a head cell while a pass over the table runs, and stands still
// otherwise. A query or a null free is answered without a pass. An
// allocate or free that succeeds first time takes one pass. Each merge
// attempt takes a pick pass and a find pass per candidate extent (only
// the pick pass for an empty one) plus a pass to apply, then retries.
// Reset gives one free extent holding the pool (base 0, 65536 bytes).
// A write on the configuration port refills the table with the
// whole pool and must happen only while no request is in work.
// If the receiver stalls, the result stays on m_tdata and the sequencer
// holds the next request's result until the register empties.
// Depends on fea_pkg, fea_cell, fea_ctrl.
module free_extent_allocator #(
    parameter int SLOT_COUNT   = 16,
    parameter int HEADER_BYTES = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // func[1:0], request_size[33:2], block_address[65:34], zero fill
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fea_pkg::S_DATA_W-1:0]  s_tdata,
    // status[1:0], granted_address[33:2], free_bytes[65:34],
    // used_bytes[97:66], zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fea_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_we,
    input  logic [fea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    fea_pkg::slot_t     slots [SLOT_COUNT];
    fea_pkg::slot_t     wb;
    fea_pkg::slot_t     load_val;
    fea_pkg::slot_t     zero_slot;
    fea_pkg::cell_ctl_t cell_ctl;

    assign zero_slot = '0;

    // rotating slot ring, head cell at index 0
    genvar k;
    generate
        for (k = 0; k < SLOT_COUNT; k++)
        begin : g_cell
            if (k == SLOT_COUNT - 1)
            begin : g_tail
                fea_cell #(.HEAD(k == 0)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctl      (cell_ctl),
                    .load_val ((k == 0) ? load_val : zero_slot),
                    .next_in  (wb),
                    .slot     (slots[k])
                );
            end
            else
            begin : g_body
                fea_cell #(.HEAD(k == 0)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctl      (cell_ctl),
                    .load_val ((k == 0) ? load_val : zero_slot),
                    .next_in  (slots[k+1]),
                    .slot     (slots[k])
                );
            end
        end
    endgenerate

    fea_ctrl #(
        .SLOT_COUNT   (SLOT_COUNT),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (slots[0]),
        .wb        (wb),
        .load_val  (load_val),
        .cell_ctl  (cell_ctl)
    );

endmodule

### tb/tb.sv
// Testbench for free_extent_allocator: random and directed alloc/free/query
// requests checked against an in-bench extent table predictor.
// Depends on fea_pkg and the free_extent_allocator RTL.
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS  = 16;
    localparam int HDR    = 4;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int STALL_CAP = 200000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted;
        logic [31:0] free_bytes;
        logic [31:0] used_bytes;
    } outcome_t;

    // Extent table predictor plus a queue of pending outcomes
    class extent_board;
        logic [31:0] base_addr;
        logic [31:0] pool_bytes;
        logic [31:0] ext_start [SLOTS];
        logic [31:0] ext_len [SLOTS];
        outcome_t pending[$];
        int errors;

        function new();
            base_addr  = fea_pkg::POOL_BASE_RST;
            pool_bytes = fea_pkg::POOL_SIZE_RST;
            errors = 0;
            refill();
        endfunction

        function void refill();
            for (int i = 0; i < SLOTS; i++)
            begin
                ext_start[i] = 0;
                ext_len[i]   = 0;
            end
            ext_start[0] = base_addr;
            ext_len[0]   = pool_bytes;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == fea_pkg::CFG_POOL_BASE)
                base_addr = val;
            else
                pool_bytes = val;
            refill();
        endfunction

        // join the first extent that has a partner with the first extent that starts at its end
        function bit merge_pair();
            logic [31:0] tail;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (ext_len[i] == 0)
                    continue;
                tail = ext_start[i] + ext_len[i];
                for (int j = 0; j < SLOTS; j++)
                begin
                    if (j != i && ext_len[j] != 0 && ext_start[j] == tail)
                    begin
                        ext_len[i] += ext_len[j];
                        ext_start[j] = 0;
                        ext_len[j] = 0;
                        return 1;
                    end
                end
            end
            return 0;
        endfunction

        function void note_request(logic [1:0] fn, logic [31:0] sz, logic [31:0] addr);
            outcome_t o;
            logic [32:0] need;
            logic [31:0] sum;
            bit done;
            o = '0;
            if (fn == fea_pkg::FUNC_ALLOC)
            begin
                need = {1'b0, sz} + HDR;
                o.status = fea_pkg::STS_NO_SPACE;
                done = 0;
                do
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (ext_len[i] != 0 && {1'b0, ext_len[i]} >= need)
                        begin
                            o.granted = ext_start[i] + HDR;
                            ext_len[i] -= need[31:0];
                            if (ext_len[i] == 0)
                                ext_start[i] = 0;
                            else
                                ext_start[i] += need[31:0];
                            o.status = fea_pkg::STS_OK;
                            done = 1;
                            break;
                        end
                    end
                end while (!done && merge_pair());
            end
            else if (fn == fea_pkg::FUNC_FREE)
            begin
                if (addr == 0)
                    o.status = fea_pkg::STS_NULL;
                else
                begin
                    need = {1'b0, sz} + HDR;
                    if (need[32])
                        need = 33'hFFFF_FFFF;
                    o.status = fea_pkg::STS_NO_SLOT;
                    done = 0;
                    do
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (ext_len[i] == 0)
                            begin
                                ext_len[i] = need[31:0];
                                ext_start[i] = (need != 0) ? addr - HDR : 32'd0;
                                o.status = fea_pkg::STS_OK;
                                done = 1;
                                break;
                            end
                        end
                    end while (!done && merge_pair());
                end
            end
            sum = 0;
            for (int i = 0; i < SLOTS; i++)
                sum += ext_len[i];
            o.free_bytes = sum;
            o.used_bytes = pool_bytes - sum;
            pending.push_back(o);
        endfunction

        function void check_result(logic [fea_pkg::M_DATA_W-1:0] data);
            outcome_t want, got;
            got.status     = data[1:0];
            got.granted    = data[33:2];
            got.free_bytes = data[65:34];
            got.used_bytes = data[97:66];
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t status exp %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.granted !== want.granted)
            begin
                $display("%0t granted exp %h got %h", $time, want.granted, got.granted);
                errors++;
            end
            if (got.free_bytes !== want.free_bytes)
            begin
                $display("%0t free exp %h got %h", $time, want.free_bytes, got.free_bytes);
                errors++;
            end
            if (got.used_bytes !== want.used_bytes)
            begin
                $display("%0t used exp %h got %h", $time, want.used_bytes, got.used_bytes);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [fea_pkg::S_DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [fea_pkg::M_DATA_W-1:0] m_tdata;
    logic cfg_we;
    logic [fea_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    extent_board board;
    int idle_cycles;
    bit hold_off;
    logic [31:0] live_addr[$];
    logic [31:0] live_size[$];

    free_extent_allocator #(.SLOT_COUNT(SLOTS), .HEADER_BYTES(HDR)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // valid stays up between back-to-back requests and drops only for a gap
    task automatic send_request(logic [1:0] fn, logic [31:0] sz, logic [31:0] addr);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, addr, sz, fn};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(fn, sz, addr);
    endtask

    // wait until every outcome is checked, then idle before the next phase
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SLOTS * SLOTS * SLOTS * 2 + 64) @(posedge clk);
    endtask

    task automatic write_reg(logic [fea_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // allocations recorded for later frees
    task automatic do_alloc(logic [31:0] sz);
        send_request(fea_pkg::FUNC_ALLOC, sz, 32'd0);
        if (board.pending[$].status == fea_pkg::STS_OK)
        begin
            live_addr.push_back(board.pending[$].granted);
            live_size.push_back(sz);
        end
    endtask

    task automatic random_phase(int count, logic [31:0] size_cap);
        int r;
        int k;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                do_alloc($urandom_range(0, size_cap));
            else if (r < 80 && live_addr.size() != 0)
            begin
                k = $urandom_range(0, live_addr.size() - 1);
                send_request(fea_pkg::FUNC_FREE, live_size[k], live_addr[k]);
                live_addr.delete(k);
                live_size.delete(k);
            end
            else if (r < 88)
                send_request(fea_pkg::FUNC_FREE, $urandom(), $urandom());
            else if (r < 92)
                send_request(fea_pkg::FUNC_ALLOC, $urandom(), $urandom());
            else if (r < 95)
                send_request(fea_pkg::FUNC_FREE, $urandom(), 32'd0);
            else
                send_request(2'($urandom_range(FUNC_QUERY, FUNC_SPARE)), $urandom(), $urandom());
        end
    endtask

    // receiver: random ready, plus one long forced hold-off
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(0, 99) < 70) ||
                            ($urandom_range(0, 9) == 0 && gap_len() == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_CAP)
        begin
            $display("free_extent_allocator: mismatch");
            $finish;
        end
    end

    initial
    begin
        board = new();
        idle_cycles = 0;
        hold_off = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, each function, special cases
        send_request(FUNC_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_SPARE, 32'h0, 32'h0);
        do_alloc(32'd0);
        do_alloc(32'd100);
        send_request(fea_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(fea_pkg::FUNC_ALLOC, 32'hFFFF_FFFC, 32'd0);
        send_request(fea_pkg::FUNC_FREE, 32'd100, 32'd0);
        send_request(fea_pkg::FUNC_FREE, 32'hFFFF_FFFC, 32'd0);
        send_request(fea_pkg::FUNC_FREE, 32'd100, 32'd8);
        send_request(fea_pkg::FUNC_FREE, 32'hFFFF_FFFF, 32'h0000_0002);
        send_request(fea_pkg::FUNC_FREE, 32'd0, 32'hFFFF_FFFF);
        send_request(fea_pkg::FUNC_FREE, 32'd0, 32'd4);
        do_alloc(32'd65000);
        for (int i = 0; i < 16; i++)
            send_request(fea_pkg::FUNC_FREE, 32'd4, 32'h1000_0000 + 32'h10 * i);
        drain();

        // long receiver hold-off while requests keep coming
        hold_off = 1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            random_phase(20, 32'd512);
        join
        drain();

        // configuration sweep
        write_reg(fea_pkg::CFG_POOL_BASE, 32'hFFFF_FF00);
        write_reg(fea_pkg::CFG_POOL_SIZE, 32'h0000_0400);
        live_addr.delete(); live_size.delete();
        random_phase(250, 32'd128);
        drain();
        write_reg(fea_pkg::CFG_POOL_BASE, 32'd0);
        write_reg(fea_pkg::CFG_POOL_SIZE, 32'hFFFF_FFFF);
        live_addr.delete(); live_size.delete();
        random_phase(250, 32'hFFFF_FFFF);
        drain();
        write_reg(fea_pkg::CFG_POOL_SIZE, 32'd0);
        live_addr.delete(); live_size.delete();
        random_phase(100, 32'd64);
        drain();
        write_reg(fea_pkg::CFG_POOL_BASE, 32'h8000_0000);
        write_reg(fea_pkg::CFG_POOL_SIZE, 32'd4096);
        live_addr.delete(); live_size.delete();
        random_phase(360, 32'd300);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("free_extent_allocator: match");
        else
            $display("free_extent_allocator: mismatch");
        $finish;
    end
endmodule

### filelist.f
+incdir+hdl
hdl/fea_pkg.sv
hdl/fea_cell.sv
hdl/fea_ctrl.sv
hdl/free_extent_allocator.sv
tb/tb.sv
